// ===== hdl/slts_pkg.sv =====
package slts_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int MAX_RES = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_SEMI = 6'd4;
    localparam logic [5:0] K_DOT = 6'd5;
    localparam logic [5:0] K_COMMA = 6'd6;
    localparam logic [5:0] K_COLON = 6'd7;
    localparam logic [5:0] K_QUEST = 6'd8;
    localparam logic [5:0] K_MINUS = 6'd9;
    localparam logic [5:0] K_MINUS2 = 6'd10;
    localparam logic [5:0] K_MINUS_EQ = 6'd11;
    localparam logic [5:0] K_PLUS = 6'd12;
    localparam logic [5:0] K_PLUS2 = 6'd13;
    localparam logic [5:0] K_PLUS_EQ = 6'd14;
    localparam logic [5:0] K_SLASH = 6'd15;
    localparam logic [5:0] K_SLASH_EQ = 6'd16;
    localparam logic [5:0] K_STAR = 6'd17;
    localparam logic [5:0] K_STAR_EQ = 6'd18;
    localparam logic [5:0] K_BANG_EQ = 6'd19;
    localparam logic [5:0] K_EQ = 6'd20;
    localparam logic [5:0] K_EQ_EQ = 6'd21;
    localparam logic [5:0] K_LESS = 6'd22;
    localparam logic [5:0] K_LESS_EQ = 6'd23;
    localparam logic [5:0] K_GREATER = 6'd24;
    localparam logic [5:0] K_GREATER_EQ = 6'd25;
    localparam logic [5:0] K_STRING = 6'd26;
    localparam logic [5:0] K_NUMBER = 6'd27;
    localparam logic [5:0] K_IDENT = 6'd28;
    localparam logic [5:0] K_AND = 6'd29;
    localparam logic [5:0] K_BREAK = 6'd30;
    localparam logic [5:0] K_CLASS = 6'd31;
    localparam logic [5:0] K_CYCLE = 6'd32;
    localparam logic [5:0] K_ELSE = 6'd33;
    localparam logic [5:0] K_FALSE = 6'd34;
    localparam logic [5:0] K_FOR = 6'd35;
    localparam logic [5:0] K_FUN = 6'd36;
    localparam logic [5:0] K_IF = 6'd37;
    localparam logic [5:0] K_NIL = 6'd38;
    localparam logic [5:0] K_NOT = 6'd39;
    localparam logic [5:0] K_OR = 6'd40;
    localparam logic [5:0] K_PRINT = 6'd41;
    localparam logic [5:0] K_RETURN = 6'd42;
    localparam logic [5:0] K_SUPER = 6'd43;
    localparam logic [5:0] K_THIS = 6'd44;
    localparam logic [5:0] K_TRUE = 6'd45;
    localparam logic [5:0] K_VAR = 6'd46;
    localparam logic [5:0] K_WHILE = 6'd47;
    localparam logic [5:0] K_ERROR = 6'd48;
    localparam logic [5:0] K_END = 6'd49;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_STRING = 2'd2;
    localparam logic [1:0] ERR_COMMENT = 2'd3;

    typedef enum logic [10:0] {
        M_IDLE     = 11'b00000000001,
        M_HASH     = 11'b00000000010,
        M_LINECMT  = 11'b00000000100,
        M_BLOCK    = 11'b00000001000,
        M_BRACKET  = 11'b00000010000,
        M_STRING   = 11'b00000100000,
        M_NUMBER   = 11'b00001000000,
        M_NUMDOT   = 11'b00010000000,
        M_FRACTION = 11'b00100000000,
        M_IDENT    = 11'b01000000000,
        M_OPERATOR = 11'b10000000000
    } mode_t;

    // One token request; offset/length already cut to 16 bits.
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
    } tok_t;

    // Everything one byte produces: up to four tokens.
    typedef struct packed {
        logic [2:0]             count;
        tok_t [MAX_RES-1:0]     toks;
    } batch_t;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] h);
        case (h)
            "-": return K_MINUS;
            "+": return K_PLUS;
            "/": return K_SLASH;
            "*": return K_STAR;
            "=": return K_EQ;
            "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        if (c == "=") begin
            case (h)
                "-": k = K_MINUS_EQ;
                "+": k = K_PLUS_EQ;
                "/": k = K_SLASH_EQ;
                "*": k = K_STAR_EQ;
                "!": k = K_BANG_EQ;
                "=": k = K_EQ_EQ;
                "<": k = K_LESS_EQ;
                default: k = K_GREATER_EQ;
            endcase
        end else if (h == "-" && c == "-") begin
            k = K_MINUS2;
        end else if (h == "+" && c == "+") begin
            k = K_PLUS2;
        end
        return k;
    endfunction

    // Keyword match on the first six characters plus the capped length.
    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [3:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            4'd2: begin
                if (w[15:0] == "fi") k = K_IF;
                else if (w[15:0] == "ro") k = K_OR;
            end
            4'd3: begin
                case (w[23:0])
                    "dna": k = K_AND;
                    "rof": k = K_FOR;
                    "nuf": k = K_FUN;
                    "lin": k = K_NIL;
                    "ton": k = K_NOT;
                    "rav": k = K_VAR;
                    default: k = K_IDENT;
                endcase
            end
            4'd4: begin
                case (w[31:0])
                    "esle": k = K_ELSE;
                    "siht": k = K_THIS;
                    "eurt": k = K_TRUE;
                    default: k = K_IDENT;
                endcase
            end
            4'd5: begin
                case (w[39:0])
                    "kaerb": k = K_BREAK;
                    "ssalc": k = K_CLASS;
                    "elcyc": k = K_CYCLE;
                    "eslaf": k = K_FALSE;
                    "tnirp": k = K_PRINT;
                    "repus": k = K_SUPER;
                    "elihw": k = K_WHILE;
                    default: k = K_IDENT;
                endcase
            end
            4'd6: begin
                if (w == "nruter") k = K_RETURN;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/slts_front.sv =====
module slts_front import slts_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       in_ready,
    output logic       b_valid,
    output batch_t     b_data,
    input  logic       b_ready
);

    localparam int WB = 8 * KEYWORD_CHARS;
    localparam int CB = $clog2(KEYWORD_CHARS + 2);
    localparam int QB = $clog2(QUEUE_DEPTH);

    mode_t                    mode_reg, mode_next;
    logic [7:0]               held_reg, held_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, begin_reg, begin_next;
    logic [15:0]              line_reg, line_next;
    logic [WB-1:0]            word_reg, word_next;
    logic [CB-1:0]            cnt_reg, cnt_next;
    batch_t                   out_next;

    // batch queue between scanner and token output
    batch_t                   q_mem_reg [QUEUE_DEPTH];
    logic [QB-1:0]            wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QB:0]              q_cnt_reg, q_cnt_next;

    logic accept, push, pop;

    function automatic logic [15:0] lo16(input logic [POSITION_BITS-1:0] v);
        return 16'(v);
    endfunction

    function automatic batch_t push_tok(input batch_t b, input logic [5:0] k,
                                        input logic [1:0] e, input logic [15:0] o,
                                        input logic [15:0] l, input logic [15:0] ln);
        batch_t r;
        r = b;
        if (r.count < 3'(MAX_RES)) begin
            r.toks[r.count[1:0]].kind = k;
            r.toks[r.count[1:0]].err = e;
            r.toks[r.count[1:0]].offset = o;
            r.toks[r.count[1:0]].length = l;
            r.toks[r.count[1:0]].line = ln;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    // Close the pending token; p is the position just past what has been seen.
    function automatic batch_t close_tok(input batch_t b, input mode_t m,
                                         input logic [POSITION_BITS-1:0] p,
                                         input logic [POSITION_BITS-1:0] bg,
                                         input logic [7:0] h, input logic [5:0] wk,
                                         input logic [15:0] ln);
        logic [POSITION_BITS-1:0] sp;
        batch_t r;
        sp = p - bg;
        r = b;
        case (m) inside
            M_STRING: r = push_tok(r, K_ERROR, ERR_STRING, lo16(bg), lo16(sp), ln);
            M_BLOCK, M_BRACKET: r = push_tok(r, K_ERROR, ERR_COMMENT, lo16(bg), lo16(sp), ln);
            M_NUMBER, M_FRACTION: r = push_tok(r, K_NUMBER, ERR_NONE, lo16(bg), lo16(sp), ln);
            M_NUMDOT: begin
                r = push_tok(r, K_NUMBER, ERR_NONE, lo16(bg), lo16(sp - 1'b1), ln);
                r = push_tok(r, K_DOT, ERR_NONE, lo16(p - 1'b1), 16'd1, ln);
            end
            M_IDENT: r = push_tok(r, wk, ERR_NONE, lo16(bg), lo16(sp), ln);
            M_OPERATOR: begin
                if (h == "!") r = push_tok(r, K_ERROR, ERR_UNEXPECTED, lo16(bg), 16'd1, ln);
                else r = push_tok(r, single_op(h), ERR_NONE, lo16(bg), 16'd1, ln);
            end
            default: ;
        endcase
        return r;
    endfunction

    assign in_ready = (q_cnt_reg != (QB+1)'(QUEUE_DEPTH));
    assign accept = in_valid && in_ready;
    assign push = accept && (out_next.count != 3'd0);
    assign b_valid = (q_cnt_reg != '0);
    assign b_data = q_mem_reg[rd_ptr_reg];
    assign pop = b_valid && b_ready;

    assign wr_ptr_next = wr_ptr_reg + QB'(push);
    assign rd_ptr_next = rd_ptr_reg + QB'(pop);
    assign q_cnt_next = q_cnt_reg + (QB+1)'(push) - (QB+1)'(pop);

    always_comb begin
        logic [7:0] c;
        logic done, idle_it;
        logic [5:0] k;

        mode_next = mode_reg;
        held_next = held_reg;
        pos_next = pos_reg;
        begin_next = begin_reg;
        line_next = line_reg;
        word_next = word_reg;
        cnt_next = cnt_reg;
        out_next = '0;
        c = in_byte;
        idle_it = 1'b0;
        done = 1'b0;
        k = '0;

        if (c != 8'd0) begin
            pos_next = pos_reg + 1'b1;
            // per-mode continuation; done means the pending token is closed
            unique case (mode_reg)
                M_IDLE: idle_it = 1'b1;
                M_HASH: begin
                    if (c == "[") mode_next = M_BLOCK;
                    else if (c == 8'h0a) begin
                        if (line_next != 16'hffff) line_next = line_next + 16'd1;
                        mode_next = M_IDLE;
                    end else mode_next = M_LINECMT;
                end
                M_LINECMT: if (c == 8'h0a) begin
                    if (line_next != 16'hffff) line_next = line_next + 16'd1;
                    mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    if (c == "]") mode_next = M_BRACKET;
                    else if (c == 8'h0a && line_next != 16'hffff) line_next = line_next + 16'd1;
                end
                M_BRACKET: begin
                    if (c == "#") mode_next = M_IDLE;
                    else if (c != "]") begin
                        if (c == 8'h0a && line_next != 16'hffff) line_next = line_next + 16'd1;
                        mode_next = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (c == 8'h22) begin
                        out_next = push_tok(out_next, K_STRING, ERR_NONE, lo16(begin_reg),
                            lo16(pos_reg + 1'b1 - begin_reg), line_next);
                        mode_next = M_IDLE;
                    end else if (c == 8'h0a && line_next != 16'hffff) begin
                        line_next = line_next + 16'd1;
                    end
                end
                M_NUMBER: begin
                    if (c == ".") mode_next = M_NUMDOT;
                    else if (!is_dig(c)) done = 1'b1;
                end
                M_NUMDOT: begin
                    if (is_dig(c)) mode_next = M_FRACTION;
                    else done = 1'b1;
                end
                M_FRACTION: if (!is_dig(c)) done = 1'b1;
                M_IDENT: begin
                    if (is_letter(c) || is_dig(c)) begin
                        if (int'(cnt_reg) < KEYWORD_CHARS)
                            word_next[int'(cnt_reg) * 8 +: 8] = c;
                        if (int'(cnt_reg) <= KEYWORD_CHARS) cnt_next = cnt_reg + 1'b1;
                    end else done = 1'b1;
                end
                M_OPERATOR: begin
                    k = pair_op(held_reg, c);
                    if (k != 6'd0) begin
                        out_next = push_tok(out_next, k, ERR_NONE, lo16(begin_reg), 16'd2,
                            line_next);
                        mode_next = M_IDLE;
                    end else done = 1'b1;
                end
                default: idle_it = 1'b1;
            endcase
            if (done) begin
                out_next = close_tok(out_next, mode_reg, pos_reg, begin_reg, held_reg,
                    word_kind(word_reg[47:0], 4'(cnt_reg)), line_next);
                idle_it = 1'b1;
            end
            if (idle_it) begin
                mode_next = M_IDLE;
                case (c) inside
                    " ", 8'h0d, 8'h09: ;
                    8'h0a: if (line_next != 16'hffff) line_next = line_next + 16'd1;
                    "(": out_next = push_tok(out_next, K_LPAREN, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    ")": out_next = push_tok(out_next, K_RPAREN, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    "{": out_next = push_tok(out_next, K_LBRACE, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    "}": out_next = push_tok(out_next, K_RBRACE, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    ";": out_next = push_tok(out_next, K_SEMI, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    ".": out_next = push_tok(out_next, K_DOT, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    ",": out_next = push_tok(out_next, K_COMMA, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    ":": out_next = push_tok(out_next, K_COLON, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    "?": out_next = push_tok(out_next, K_QUEST, ERR_NONE, lo16(pos_reg), 16'd1,
                        line_next);
                    "-", "+", "/", "*", "!", "=", "<", ">": begin
                        held_next = c;
                        begin_next = pos_reg;
                        mode_next = M_OPERATOR;
                    end
                    "#": begin
                        begin_next = pos_reg;
                        mode_next = M_HASH;
                    end
                    8'h22: begin
                        begin_next = pos_reg;
                        mode_next = M_STRING;
                    end
                    default: begin
                        if (is_letter(c)) begin
                            begin_next = pos_reg;
                            word_next = '0;
                            word_next[7:0] = c;
                            cnt_next = CB'(1);
                            mode_next = M_IDENT;
                        end else if (is_dig(c)) begin
                            begin_next = pos_reg;
                            mode_next = M_NUMBER;
                        end else begin
                            out_next = push_tok(out_next, K_ERROR, ERR_UNEXPECTED,
                                lo16(pos_reg), 16'd1, line_next);
                        end
                    end
                endcase
            end
        end
        // zero byte or tlast: close, emit end token, start a fresh source
        if (c == 8'd0 || in_last) begin
            out_next = close_tok(out_next, mode_next, pos_next, begin_next, held_next,
                word_kind(word_next[47:0], 4'(cnt_next)), line_next);
            out_next = push_tok(out_next, K_END, ERR_NONE, lo16(pos_next), 16'd0, line_next);
            mode_next = M_IDLE;
            held_next = '0;
            pos_next = '0;
            begin_next = '0;
            line_next = 16'd1;
            word_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            held_reg <= '0;
            pos_reg <= '0;
            begin_reg <= '0;
            line_reg <= 16'd1;
            word_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            pos_reg <= pos_next;
            begin_reg <= begin_next;
            line_reg <= line_next;
            word_reg <= word_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= out_next;
    end

`ifndef ASSERT_OFF
    a_qbound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= (QB+1)'(QUEUE_DEPTH))
        else $error("batch queue over depth");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid && !b_ready) |=> (b_valid && $stable(b_data)))
        else $error("queued batch changed while waiting");
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != 16'd0)
        else $error("line counter at zero");
`endif

endmodule

// ===== hdl/slts_back.sv =====
module slts_back import slts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  batch_t      q_data,
    output logic        q_ready,
    output logic        m_valid,
    output logic [55:0] m_data,
    output logic        m_last,
    input  logic        m_ready
);

    logic [1:0] idx_reg, idx_next;
    logic       last_tok;
    tok_t       cur;

    assign cur = q_data.toks[idx_reg];
    assign last_tok = ({1'b0, idx_reg} + 3'd1) == q_data.count;
    assign m_valid = q_valid;
    assign m_data = {cur.line, cur.length, cur.offset, cur.err, cur.kind};
    assign m_last = last_tok;
    assign q_ready = m_ready && last_tok;

    always_comb begin
        idx_next = idx_reg;
        if (q_valid && m_ready) idx_next = last_tok ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) idx_reg <= '0;
        else idx_reg <= idx_next;
    end

`ifndef ASSERT_OFF
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_data.count != 3'd0 && q_data.count <= 3'd4))
        else $error("empty batch in queue");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> ({1'b0, idx_reg} < q_data.count))
        else $error("token index past batch");
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && cur.kind == K_END) |-> last_tok)
        else $error("end token not last");
`endif

endmodule

// ===== hdl/script_lexer_token_stream.sv =====
// Scanner: one source byte per cycle in while s_tready is high, tokens out.
// A byte yields 0..4 tokens, usually completing the token before it, so most
// tokens leave one byte late. A zero byte, or tlast on the input, closes the
// source with an end token. Tokens enter a two-entry batch queue when the byte
// that completes them is accepted. Output runs at one token per cycle while
// m_tready is high: a byte's tokens leave one by one, and the queue lets bytes
// that yield none catch up. s_tready drops only while that queue is full.
module script_lexer_token_stream import slts_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // source_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // token_kind, error_kind, token_offset, token_length, line_number
    output logic        m_tlast    // final_of_run
);

    logic   f_valid, f_ready;
    batch_t f_data;

    slts_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_byte(s_tdata), .in_last(s_tlast), .in_ready(s_tready),
        .b_valid(f_valid), .b_data(f_data), .b_ready(f_ready)
    );

    slts_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(f_valid), .q_data(f_data), .q_ready(f_ready),
        .m_valid(m_tvalid), .m_data(m_tdata), .m_last(m_tlast), .m_ready(m_tready)
    );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import slts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        LX_IDLE, LX_HASH, LX_LINECMT, LX_BLOCK, LX_BRACKET, LX_STRING,
        LX_NUMBER, LX_NUMDOT, LX_FRACTION, LX_IDENT, LX_OPERATOR
    } lex_state_e;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_rec_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } src_req_t;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    script_lexer_token_stream i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    src_req_t   pending_src[$];
    token_rec_t expected_tokens[$];
    int         fail_count;
    bit         stim_done;
    int         idle_cycles;

    // scanner shadow state
    lex_state_e  sc_state;
    logic [7:0]  sc_held;
    logic [15:0] sc_pos;
    logic [15:0] sc_begin;
    logic [15:0] sc_line;
    logic [47:0] sc_word;
    int          sc_wcount;
    token_rec_t  batch[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void scan_reset();
        sc_state = LX_IDLE;
        sc_held = 8'd0;
        sc_pos = '0;
        sc_begin = '0;
        sc_line = 16'd1;
        sc_word = '0;
        sc_wcount = 0;
    endfunction

    function automatic void emit(logic [5:0] k, logic [1:0] e, logic [15:0] o, logic [15:0] l);
        token_rec_t t;
        t.kind = k;
        t.err = e;
        t.offset = o;
        t.length = l;
        t.line = sc_line;
        t.last = 1'b0;
        if (batch.size() < MAX_RES) batch.push_back(t);
    endfunction

    function automatic void bump_line();
        if (sc_line != 16'hffff) sc_line = sc_line + 16'd1;
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] keyword_of();
        string kw[19] = '{"and", "break", "class", "cycle", "else", "false", "for",
                          "fun", "if", "nil", "not", "or", "print", "return", "super",
                          "this", "true", "var", "while"};
        bit same;
        for (int k = 0; k < 19; k++) begin
            if (kw[k].len() != sc_wcount) continue;
            same = 1;
            for (int i = 0; i < kw[k].len(); i++)
                if (sc_word[8*i +: 8] != kw[k][i]) same = 0;
            if (same) return 6'(29 + k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [5:0] lone_op(logic [7:0] h);
        case (h)
            "-": return K_MINUS;
            "+": return K_PLUS;
            "/": return K_SLASH;
            "*": return K_STAR;
            "=": return K_EQ;
            "<": return K_LESS;
            default: return K_GREATER;
        endcase
    endfunction

    function automatic logic [5:0] two_char_op(logic [7:0] h, logic [7:0] c);
        if (c == "=") begin
            case (h)
                "-": return K_MINUS_EQ;
                "+": return K_PLUS_EQ;
                "/": return K_SLASH_EQ;
                "*": return K_STAR_EQ;
                "!": return K_BANG_EQ;
                "=": return K_EQ_EQ;
                "<": return K_LESS_EQ;
                default: return K_GREATER_EQ;
            endcase
        end
        if (h == "-" && c == "-") return K_MINUS2;
        if (h == "+" && c == "+") return K_PLUS2;
        return 6'd0;
    endfunction

    function automatic void close_token(logic [15:0] p);
        case (sc_state) inside
            LX_STRING: emit(K_ERROR, ERR_STRING, sc_begin, p - sc_begin);
            LX_BLOCK, LX_BRACKET: emit(K_ERROR, ERR_COMMENT, sc_begin, p - sc_begin);
            LX_NUMBER, LX_FRACTION: emit(K_NUMBER, ERR_NONE, sc_begin, p - sc_begin);
            LX_NUMDOT: begin
                emit(K_NUMBER, ERR_NONE, sc_begin, p - sc_begin - 16'd1);
                emit(K_DOT, ERR_NONE, p - 16'd1, 16'd1);
            end
            LX_IDENT: emit(keyword_of(), ERR_NONE, sc_begin, p - sc_begin);
            LX_OPERATOR: begin
                if (sc_held == "!") emit(K_ERROR, ERR_UNEXPECTED, sc_begin, 16'd1);
                else emit(lone_op(sc_held), ERR_NONE, sc_begin, 16'd1);
            end
            default: ;
        endcase
        sc_state = LX_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] p);
        case (c) inside
            " ", 8'h0d, "\t": ;
            "\n": bump_line();
            "(": emit(K_LPAREN, ERR_NONE, p, 16'd1);
            ")": emit(K_RPAREN, ERR_NONE, p, 16'd1);
            "{": emit(K_LBRACE, ERR_NONE, p, 16'd1);
            "}": emit(K_RBRACE, ERR_NONE, p, 16'd1);
            ";": emit(K_SEMI, ERR_NONE, p, 16'd1);
            ".": emit(K_DOT, ERR_NONE, p, 16'd1);
            ",": emit(K_COMMA, ERR_NONE, p, 16'd1);
            ":": emit(K_COLON, ERR_NONE, p, 16'd1);
            "?": emit(K_QUEST, ERR_NONE, p, 16'd1);
            "-", "+", "/", "*", "!", "=", "<", ">": begin
                sc_held = c;
                sc_begin = p;
                sc_state = LX_OPERATOR;
            end
            "#": begin
                sc_begin = p;
                sc_state = LX_HASH;
            end
            "\"": begin
                sc_begin = p;
                sc_state = LX_STRING;
            end
            default: begin
                if (letter(c)) begin
                    sc_begin = p;
                    sc_word = '0;
                    sc_word[7:0] = c;
                    sc_wcount = 1;
                    sc_state = LX_IDENT;
                end else if (digit(c)) begin
                    sc_begin = p;
                    sc_state = LX_NUMBER;
                end else begin
                    emit(K_ERROR, ERR_UNEXPECTED, p, 16'd1);
                end
            end
        endcase
    endfunction

    function automatic void scan_char(logic [7:0] c, logic [15:0] p);
        logic [5:0] k;
        case (sc_state)
            LX_HASH: begin
                if (c == "[") sc_state = LX_BLOCK;
                else if (c == "\n") begin
                    bump_line();
                    sc_state = LX_IDLE;
                end else sc_state = LX_LINECMT;
                return;
            end
            LX_LINECMT: begin
                if (c == "\n") begin
                    bump_line();
                    sc_state = LX_IDLE;
                end
                return;
            end
            LX_BLOCK: begin
                if (c == "]") sc_state = LX_BRACKET;
                else if (c == "\n") bump_line();
                return;
            end
            LX_BRACKET: begin
                if (c == "#") sc_state = LX_IDLE;
                else if (c != "]") begin
                    if (c == "\n") bump_line();
                    sc_state = LX_BLOCK;
                end
                return;
            end
            LX_STRING: begin
                if (c == "\"") begin
                    emit(K_STRING, ERR_NONE, sc_begin, p + 16'd1 - sc_begin);
                    sc_state = LX_IDLE;
                end else if (c == "\n") bump_line();
                return;
            end
            LX_NUMBER: begin
                if (digit(c)) return;
                if (c == ".") begin
                    sc_state = LX_NUMDOT;
                    return;
                end
            end
            LX_NUMDOT: begin
                if (digit(c)) begin
                    sc_state = LX_FRACTION;
                    return;
                end
            end
            LX_FRACTION: begin
                if (digit(c)) return;
            end
            LX_IDENT: begin
                if (letter(c) || digit(c)) begin
                    if (sc_wcount < 6) sc_word[8*sc_wcount +: 8] = c;
                    if (sc_wcount <= 6) sc_wcount++;
                    return;
                end
            end
            LX_OPERATOR: begin
                k = two_char_op(sc_held, c);
                if (k != 6'd0) begin
                    emit(k, ERR_NONE, sc_begin, 16'd2);
                    sc_state = LX_IDLE;
                    return;
                end
            end
            default: begin
                start_token(c, p);
                return;
            end
        endcase
        close_token(p);
        start_token(c, p);
    endfunction

    function automatic void end_source(logic [15:0] p);
        close_token(p);
        emit(K_END, ERR_NONE, p, 16'd0);
        scan_reset();
    endfunction

    function automatic void predict_tokens(src_req_t r);
        batch.delete();
        if (r.ch == 8'd0) end_source(sc_pos);
        else begin
            scan_char(r.ch, sc_pos);
            sc_pos = sc_pos + 16'd1;
            if (r.eos) end_source(sc_pos);
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) expected_tokens.push_back(batch[i]);
    endfunction

    // stimulus helpers
    function automatic void add_text(string s, bit close = 1);
        src_req_t r;
        for (int i = 0; i < s.len(); i++) begin
            r.ch = s[i];
            r.eos = close && (i == s.len() - 1);
            pending_src.push_back(r);
        end
    endfunction

    function automatic void add_byte(logic [7:0] c, bit e);
        src_req_t r;
        r.ch = c;
        r.eos = e;
        pending_src.push_back(r);
    endfunction

    function automatic string pick_fragment();
        string frag[] = '{"and ", "break", "class ", "cycle;", "else{", "false)",
                          "for(", "fun ", "if ", "nil,", "not ", "or ", "print ",
                          "return;", "returned ", "super.", "this ", "true ", "var x_9",
                          "while ", "whiles ", "12.5 ", "7.", "42.x", "\"hi\\n\"",
                          "\"a\nb\" ", "#c\n", "#[ x\n]]#", "#[]#", "-- ", "-= ", "++",
                          "+= ", "/= ", "*= ", "!= ", "== ", "<= ", ">= ", "! ", "<>",
                          "/*", "\n", "\t\015 ", "(){};.,:?", "@$", "Zz_0", "3;"};
        return frag[$urandom_range(0, frag.size() - 1)];
    endfunction

    initial begin
        src_req_t r;
        int n;
        string s;
        scan_reset();
        fail_count = 0;
        stim_done = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;

        // directed
        add_text("if(x>=1.5){print \"s\";}#c\n");
        add_text("returns return whilex --a!b !=");
        add_text("#[ a ]]# 3. \"open");
        add_text("#[ never closed");
        add_byte(8'hff, 0);
        add_byte(8'h80, 0);
        add_byte(8'h01, 0);
        add_byte(8'h00, 1);
        add_text("#", 0);
        add_byte(8'h00, 0);
        add_text("9.", 1);

        // random: mostly well-formed fragments, some raw noise
        while (pending_src.size() < 440) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    r.ch = 8'($urandom_range(1, 255));
                    r.eos = 0;
                    pending_src.push_back(r);
                end else begin
                    s = pick_fragment();
                    add_text(s, 0);
                end
            end
            if ($urandom_range(0, 3) == 0) add_byte(8'd0, bit'($urandom_range(0, 1)));
            else pending_src[pending_src.size()-1].eos = 1;
        end
        add_byte(8'd0, 1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: bursts with gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_src.size() > 0) begin
                r_drive();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    task automatic r_drive();
        src_req_t r;
        r = pending_src.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= r.ch;
        s_tlast <= r.eos;
        predict_tokens(r);
    endtask

    // receiver stall pattern
    logic [15:0] stall_lfsr;
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_lfsr <= 16'hace1;
            m_tready <= 1'b0;
        end else begin
            stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13]
                           ^ stall_lfsr[12] ^ stall_lfsr[10]};
            m_tready <= stall_lfsr[3] ? 1'b1 : (stall_lfsr[7:5] != 3'b000);
        end
    end

    // monitor
    always @(posedge aclk) begin
        token_rec_t got;
        token_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tdata[7:6], m_tdata[23:8], m_tdata[39:24],
                   m_tdata[55:40], m_tlast};
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token kind=%0d", $time, got.kind);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    $display("%0t: expected kind=%0d err=%0d off=%0d len=%0d line=%0d last=%0b",
                             $time, want.kind, want.err, want.offset, want.length,
                             want.line, want.last);
                    $display("%0t: actual   kind=%0d err=%0d off=%0d len=%0d line=%0d last=%0b",
                             $time, got.kind, got.err, got.offset, got.length,
                             got.line, got.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        wait (stim_done && expected_tokens.size() == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && expected_tokens.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
